>>> rtl/core/set_assoc_cache_tag_data_array_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef SET_ASSOC_CACHE_TAG_DATA_ARRAY_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_DATA_ARRAY_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SACTA_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("sacta: same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define SACTA_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("sacta: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SACTA_ASSERT_NEXT_ALWAYS(label, clk, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("sacta: check across reset failed");

`endif

>>> rtl/core/sacta_pkg.sv
`timescale 1ns / 1ps

package sacta_pkg;

  localparam int INDEX_COUNT = 64;
  localparam int WAYS        = 4;
  localparam int LINE_BYTES  = 32;

  localparam int ADDR_W      = 32;
  localparam int OFFSET_W    = $clog2(LINE_BYTES);
  localparam int INDEX_W     = $clog2(INDEX_COUNT);
  localparam int SET_W       = (INDEX_W > 0) ? INDEX_W : 1;
  localparam int TAG_W       = ADDR_W - OFFSET_W - INDEX_W;
  localparam int ENTRY_COUNT = INDEX_COUNT * WAYS;
  localparam int DWORDS      = LINE_BYTES / 8;
  localparam int DATA_DEPTH  = ENTRY_COUNT * DWORDS;
  localparam int DADDR_W     = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] KIND_LOOKUP  = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_WRITE   = 2'd2;
  localparam logic [1:0] KIND_INSTALL = 2'd3;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SET_W-1:0]    set;
    logic [TAG_W-1:0]    tag;
    logic [OFFSET_W-1:0] offset;
    logic [1:0]          size;
    logic [1:0]          way;
    logic [63:0]         wval;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] hit_way;
  } lookup_t;

  function automatic logic [SET_W-1:0] addr_set(logic [ADDR_W-1:0] address);
    logic [SET_W-1:0] s;
    s = '0;
    if (INDEX_W > 0) begin
      s = address[OFFSET_W +: SET_W];
    end
    return s;
  endfunction

  function automatic logic [TAG_W-1:0] addr_tag(logic [ADDR_W-1:0] address);
    return address[ADDR_W-1 -: TAG_W];
  endfunction

  function automatic logic way_ok(logic [1:0] way);
    return {30'd0, way} < 32'(WAYS);
  endfunction

  function automatic logic [2:0] size_lsb_mask(logic [1:0] size);
    logic [2:0] m;
    case (size)
      SIZE_BYTE: m = 3'b000;
      SIZE_HALF: m = 3'b001;
      SIZE_WORD: m = 3'b011;
      default:   m = 3'b111;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] size_value_mask(logic [1:0] size);
    logic [63:0] m;
    case (size)
      SIZE_BYTE: m = 64'h0000_0000_0000_00ff;
      SIZE_HALF: m = 64'h0000_0000_0000_ffff;
      SIZE_WORD: m = 64'h0000_0000_ffff_ffff;
      default:   m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] size_bytes(logic [1:0] size);
    return 4'd1 << size;
  endfunction

  // Byte position of the access within its doubleword, low offset bits aligned down.
  function automatic logic [2:0] dword_pos(logic [OFFSET_W-1:0] offset, logic [1:0] size);
    return offset[2:0] & ~size_lsb_mask(size);
  endfunction

  // Bit shift of the value in a big-endian doubleword.
  function automatic logic [5:0] dword_shift(logic [2:0] pos, logic [1:0] size);
    logic [3:0] gap;
    gap = 4'd8 - {1'b0, pos} - size_bytes(size);
    return {gap[2:0], 3'b000};
  endfunction

endpackage

>>> rtl/core/sacta_ram.sv
`timescale 1ns / 1ps

module sacta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/sacta_tag_array.sv
`timescale 1ns / 1ps

module sacta_tag_array (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              re,
  input  sacta_pkg::req_t   req,
  input  sacta_pkg::req_t   s1_req,
  output sacta_pkg::lookup_t lookup
);

  logic [sacta_pkg::WAYS-1:0]  valid [sacta_pkg::INDEX_COUNT];
  logic [sacta_pkg::WAYS-1:0]  valid_snap;
  logic [sacta_pkg::TAG_W-1:0] tag_rd [sacta_pkg::WAYS];
  logic                        install;

  assign install = accept && (req.kind == sacta_pkg::KIND_INSTALL) && sacta_pkg::way_ok(req.way);

  for (genvar w = 0; w < sacta_pkg::WAYS; w++) begin : g_way
    sacta_ram #(
      .WIDTH(sacta_pkg::TAG_W),
      .DEPTH(sacta_pkg::INDEX_COUNT)
    ) u_tag_ram (
      .clk  (clk),
      .we   (install && ({30'd0, req.way} == 32'(w))),
      .waddr(req.set),
      .wdata(req.tag),
      .re   (re),
      .raddr(req.set),
      .rdata(tag_rd[w])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sacta_pkg::INDEX_COUNT; i++) begin
        valid[i] <= '0;
      end
    end else if (install) begin
      valid[req.set][req.way] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      valid_snap <= valid[req.set];
    end
  end

  always_comb begin
    lookup = '0;
    for (int w = sacta_pkg::WAYS - 1; w >= 0; w--) begin
      if (valid_snap[w] && (tag_rd[w] == s1_req.tag)) begin
        lookup.hit     = 1'b1;
        lookup.hit_way = 2'(w);
      end
    end
  end

endmodule

>>> rtl/core/sacta_data_array.sv
`timescale 1ns / 1ps

module sacta_data_array (
  input  logic            clk,
  input  logic            accept,
  input  logic            re,
  input  sacta_pkg::req_t req,
  input  sacta_pkg::req_t s1_req,
  output logic [63:0]     read_value
);

  logic [sacta_pkg::DADDR_W-1:0] daddr;
  logic [2:0]                    pos;
  logic [3:0]                    nbytes;
  logic [63:0]                   shifted;
  logic                          wr;
  logic [7:0]                    lane_we;
  logic [7:0]                    lane_wdata [8];
  logic [7:0]                    lane_rd [8];
  logic [63:0]                   dword;
  logic [2:0]                    s1_pos;

  assign daddr = (sacta_pkg::DADDR_W'(req.set) * sacta_pkg::DADDR_W'(sacta_pkg::WAYS)
                  + sacta_pkg::DADDR_W'(req.way)) * sacta_pkg::DADDR_W'(sacta_pkg::DWORDS)
                 + sacta_pkg::DADDR_W'(req.offset >> 3);
  assign pos     = sacta_pkg::dword_pos(req.offset, req.size);
  assign nbytes  = sacta_pkg::size_bytes(req.size);
  assign shifted = (req.wval & sacta_pkg::size_value_mask(req.size))
                   << sacta_pkg::dword_shift(pos, req.size);
  assign wr      = accept && (req.kind == sacta_pkg::KIND_WRITE) && sacta_pkg::way_ok(req.way);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      lane_we[j]    = wr && (4'(j) >= {1'b0, pos}) && (4'(j) < ({1'b0, pos} + nbytes));
      lane_wdata[j] = shifted[63 - 8 * j -: 8];
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_lane
    sacta_ram #(
      .WIDTH(8),
      .DEPTH(sacta_pkg::DATA_DEPTH)
    ) u_lane_ram (
      .clk  (clk),
      .we   (lane_we[j]),
      .waddr(daddr),
      .wdata(lane_wdata[j]),
      .re   (re),
      .raddr(daddr),
      .rdata(lane_rd[j])
    );
    assign dword[63 - 8 * j -: 8] = lane_rd[j];
  end

  assign s1_pos     = sacta_pkg::dword_pos(s1_req.offset, s1_req.size);
  assign read_value = (dword >> sacta_pkg::dword_shift(s1_pos, s1_req.size))
                      & sacta_pkg::size_value_mask(s1_req.size);

endmodule

>>> rtl/core/set_assoc_cache_tag_data_array_unit.sv
// Tag and data array of a four-way set-associative cache, 64 sets of 32-byte lines.
// Input channel s_*: s_tuser carries the kind (lookup, read, write, install);
// s_tdata carries address, access size, way and write value. A transaction is
// taken when s_tvalid and s_tready are both high.
// Output channel m_*: one result per input transaction, in order, on m_tdata
// (hit, hit way, read value), taken when m_tvalid and m_tready are both high.
// Pipeline: the tag and data memory reads are registered in the read stage, then
// the compare and alignment feed the output register that drives m_tdata.
// Throughput: one transaction per cycle while m_tready stays high; writes and
// installs land in the memories at the edge that takes them, so a following
// access in the next cycle sees them.
// Stall: when m_tready is low the output register and the read stage hold, the
// memory read data is held by its read enable, and s_tready drops once both
// are full.
// Reset (rst, synchronous): clears every valid bit at once and empties the
// pipeline; tags and data are not cleared and must be written before use.
`timescale 1ns / 1ps

module set_assoc_cache_tag_data_array_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] address, [33:32] access_size, [35:34] way_select, [99:36] write_value
  input  logic [sacta_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] hit, [2:1] hit_way, [66:3] read_value
  output logic [sacta_pkg::OUT_TDATA_W-1:0] m_tdata
);

  sacta_pkg::req_t    req;
  sacta_pkg::req_t    s1_req;
  sacta_pkg::lookup_t lookup;
  logic               accept;
  logic               s1_valid;
  logic               s1_move;
  logic               out_valid;
  logic [63:0]        rd_value;
  logic [2:0]         res_flags;
  logic [63:0]        res_value;
  logic [sacta_pkg::OUT_TDATA_W-1:0] out_data;

  always_comb begin
    req.kind   = s_tuser;
    req.set    = sacta_pkg::addr_set(s_tdata[31:0]);
    req.tag    = sacta_pkg::addr_tag(s_tdata[31:0]);
    req.offset = s_tdata[sacta_pkg::OFFSET_W-1:0];
    req.size   = s_tdata[33:32];
    req.way    = s_tdata[35:34];
    req.wval   = s_tdata[99:36];
  end

  assign s1_move  = !out_valid || m_tready;
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  sacta_tag_array u_tag_array (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .re    (s_tready),
    .req   (req),
    .s1_req(s1_req),
    .lookup(lookup)
  );

  sacta_data_array u_data_array (
    .clk       (clk),
    .accept    (accept),
    .re        (s_tready),
    .req       (req),
    .s1_req    (s1_req),
    .read_value(rd_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= req;
    end
  end

  always_comb begin
    res_flags = 3'b000;
    res_value = '0;
    case (s1_req.kind)
      sacta_pkg::KIND_LOOKUP: res_flags = {lookup.hit_way, lookup.hit};
      sacta_pkg::KIND_READ: begin
        if (sacta_pkg::way_ok(s1_req.way)) begin
          res_value = rd_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      out_data <= {5'd0, res_value, res_flags};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

>>> rtl/core/sacta_checker.sv
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_data_array_unit_assert.svh"

module sacta_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [sacta_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic in_take;

  assign in_take = s_tvalid && s_tready;

  `SACTA_ASSERT_NEXT_ALWAYS(a_reset_empties, clk, rst, !m_tvalid)
  `SACTA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SACTA_ASSERT_NEXT(a_latency, clk, rst, in_take && !m_tvalid, ##1 m_tvalid)
  `SACTA_ASSERT_NOW(a_miss_way_zero, clk, rst, m_tvalid && !m_tdata[0], m_tdata[2:1] == 2'd0)
  `SACTA_ASSERT_NOW(a_hit_no_data, clk, rst, m_tvalid && m_tdata[0], m_tdata[66:3] == 64'd0)

endmodule

bind set_assoc_cache_tag_data_array_unit sacta_checker u_sacta_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

>>> verif/sacta_result_checker.sv
`timescale 1ns / 1ps

module sacta_result_checker
  import sacta_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // [31:0] address, [33:32] access_size, [35:34] way_select, [99:36] write_value
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [1:0] kind
  input  logic [1:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] hit, [2:1] hit_way, [66:3] read_value
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     mismatches,
  output int                     results_owed,
  output int                     hits_seen
);

  typedef struct packed {
    logic        hit;
    logic [1:0]  hit_way;
    logic [63:0] read_value;
  } array_result_t;

  logic [TAG_W-1:0] shadow_tags  [ENTRY_COUNT];
  logic             shadow_valid [ENTRY_COUNT];
  logic [63:0]      shadow_lines [DATA_DEPTH];
  array_result_t    owed_results [$];
  int               result_no = 0;

  function automatic array_result_t access_cache_array(logic [1:0] kind,
      logic [ADDR_W-1:0] address, logic [1:0] size, logic [1:0] way, logic [63:0] wval);
    array_result_t    r;
    logic [TAG_W-1:0] tag;
    logic [63:0]      mask;
    int               line_set, entry, nbytes, off, dw, shift;
    r = '0;
    tag = address[ADDR_W-1 -: TAG_W];
    line_set = int'(address[OFFSET_W +: INDEX_W]);
    nbytes = 1 << size;
    if (kind == KIND_LOOKUP) begin
      // scan downwards so the lowest matching way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (shadow_valid[line_set*WAYS+w] && shadow_tags[line_set*WAYS+w] == tag) begin
          r.hit = 1'b1;
          r.hit_way = 2'(w);
        end
      end
    end else if (int'(way) < WAYS) begin
      entry = line_set * WAYS + int'(way);
      if (kind == KIND_INSTALL) begin
        shadow_tags[entry] = tag;
        shadow_valid[entry] = 1'b1;
      end else begin
        off = int'(address[OFFSET_W-1:0]) & ~(nbytes - 1);
        dw = entry * DWORDS + off / 8;
        // big-endian: byte 0 sits in the top byte of the doubleword
        shift = (8 - off % 8 - nbytes) * 8;
        mask = (nbytes == 8) ? '1 : (64'd1 << (8 * nbytes)) - 64'd1;
        if (kind == KIND_READ) begin
          r.read_value = (shadow_lines[dw] >> shift) & mask;
        end else begin
          shadow_lines[dw] = (shadow_lines[dw] & ~(mask << shift)) | ((wval & mask) << shift);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (mismatches < 100) begin
      $display("[%0t] result %0d: %s is %h, expected %h", $time, result_no, field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    array_result_t want, got;
    if (rst) begin
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      owed_results.delete();
      results_owed = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.hit = m_tdata[0];
        got.hit_way = m_tdata[2:1];
        got.read_value = m_tdata[66:3];
        if (owed_results.size() == 0) begin
          report_mismatch("unrequested result", 64'(got), 64'd0);
        end else begin
          want = owed_results.pop_front();
          if (want.hit) hits_seen++;
          if (got.hit != want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
          if (got.hit_way != want.hit_way) begin
            report_mismatch("hit_way", 64'(got.hit_way), 64'(want.hit_way));
          end
          if (got.read_value != want.read_value) begin
            report_mismatch("read_value", got.read_value, want.read_value);
          end
        end
        result_no++;
      end
      if (s_tvalid && s_tready) begin
        owed_results.push_back(access_cache_array(s_tuser, s_tdata[31:0], s_tdata[33:32],
                                                  s_tdata[35:34], s_tdata[99:36]));
      end
      results_owed = owed_results.size();
    end
  end

endmodule

>>> verif/set_assoc_cache_tag_data_array_unit_tb.sv
`timescale 1ns / 1ps

module set_assoc_cache_tag_data_array_unit_tb;
  import sacta_pkg::*;

  localparam int RANDOM_ITEMS = 1928;
  localparam int PHASES       = 8;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = KIND_LOOKUP;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int mismatches, results_owed, hits_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int kind_count [4];

  logic               byte_filled [ENTRY_COUNT*LINE_BYTES];
  logic [TAG_W-1:0]   tag_pool    [6];
  logic [INDEX_W-1:0] hot_sets    [8];

  set_assoc_cache_tag_data_array_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sacta_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .results_owed (results_owed),
    .hits_seen    (hits_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unit_base(logic [1:0] way, logic [ADDR_W-1:0] address,
                                   logic [1:0] size);
    return (int'(address[OFFSET_W +: INDEX_W]) * WAYS + int'(way)) * LINE_BYTES
           + (int'(address[OFFSET_W-1:0]) & ~((1 << size) - 1));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [TAG_W-1:0]   tag;
    logic [INDEX_W-1:0] line_set;
    tag = ($urandom_range(99) < 80) ? tag_pool[$urandom_range(5)] : TAG_W'($urandom);
    line_set = ($urandom_range(99) < 75) ? hot_sets[$urandom_range(7)] : INDEX_W'($urandom);
    return {tag, line_set, OFFSET_W'($urandom)};
  endfunction

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 64'd0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Send one transaction; turn a read of unfilled bytes into a write of the same unit.
  task automatic send(logic [1:0] kind, logic [ADDR_W-1:0] address, logic [1:0] size,
                      logic [1:0] way, logic [63:0] wval);
    int base;
    base = unit_base(way, address, size);
    if (kind == KIND_READ) begin
      for (int i = 0; i < (1 << size); i++) begin
        if (!byte_filled[base+i]) kind = KIND_WRITE;
      end
    end
    if (kind == KIND_WRITE) begin
      for (int i = 0; i < (1 << size); i++) byte_filled[base+i] = 1'b1;
    end
    kind_count[kind]++;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, wval, way, size, address};
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    int         r;
    logic [1:0] kind;
    foreach (byte_filled[i]) byte_filled[i] = 1'b0;
    foreach (kind_count[i]) kind_count[i] = 0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = TAG_W'($urandom);
    hot_sets[0] = '0;
    hot_sets[1] = '1;
    for (int i = 2; i < 8; i++) hot_sets[i] = INDEX_W'($urandom);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send(KIND_LOOKUP,  32'h0000_0000, SIZE_BYTE,  2'd0, 64'd0);
    send(KIND_INSTALL, 32'h0000_0000, SIZE_BYTE,  2'd0, 64'd0);
    send(KIND_INSTALL, 32'hffff_ffff, SIZE_DWORD, 2'd3, '1);
    // same tag in a second way of the set
    send(KIND_INSTALL, 32'h0000_0000, SIZE_BYTE,  2'd2, 64'd0);
    send(KIND_LOOKUP,  32'h0000_0000, SIZE_BYTE,  2'd1, 64'd0);
    send(KIND_LOOKUP,  32'hffff_ffff, SIZE_BYTE,  2'd0, 64'd0);
    send(KIND_LOOKUP,  32'h0000_0800, SIZE_BYTE,  2'd0, 64'd0);
    send(KIND_WRITE,   32'h0000_0000, SIZE_DWORD, 2'd0, 64'h0123_4567_89ab_cdef);
    send(KIND_WRITE,   32'h0000_0001, SIZE_BYTE,  2'd0, 64'hffff_ffff_ffff_ff5a);
    send(KIND_WRITE,   32'h0000_0003, SIZE_HALF,  2'd0, 64'hffff_ffff_ffff_beef);
    send(KIND_WRITE,   32'h0000_0006, SIZE_WORD,  2'd0, 64'hffff_ffff_dead_c0de);
    send(KIND_READ,    32'h0000_0000, SIZE_DWORD, 2'd0, 64'd0);
    send(KIND_READ,    32'h0000_0005, SIZE_BYTE,  2'd0, 64'd0);
    send(KIND_READ,    32'h0000_0007, SIZE_HALF,  2'd0, 64'd0);
    send(KIND_READ,    32'h0000_0003, SIZE_WORD,  2'd0, '1);
    send(KIND_WRITE,   32'hffff_ffff, SIZE_DWORD, 2'd3, '1);
    send(KIND_WRITE,   32'hffff_ffff, SIZE_BYTE,  2'd3, 64'd0);
    send(KIND_READ,    32'hffff_ffff, SIZE_BYTE,  2'd3, 64'd0);
    send(KIND_READ,    32'hffff_ffff, SIZE_HALF,  2'd3, 64'd0);
    send(KIND_READ,    32'hffff_ffff, SIZE_WORD,  2'd3, 64'd0);
    send(KIND_READ,    32'hffff_ffff, SIZE_DWORD, 2'd3, 64'd0);
    send(KIND_WRITE,   32'hffff_ffe0, SIZE_DWORD, 2'd1, 64'h8000_0000_0000_0001);
    send(KIND_READ,    32'hffff_ffe7, SIZE_DWORD, 2'd1, 64'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        r = $urandom_range(99);
        kind = (r < 30) ? KIND_LOOKUP : (r < 60) ? KIND_READ :
               (r < 82) ? KIND_WRITE : KIND_INSTALL;
        send(kind, pick_address(), 2'($urandom_range(3)), 2'($urandom_range(3)),
             pick_value());
      end
    end

    s_tvalid <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d lookups (%0d hits), %0d reads, %0d writes and %0d installs,",
             kind_count[KIND_LOOKUP], hits_seen, kind_count[KIND_READ],
             kind_count[KIND_WRITE], kind_count[KIND_INSTALL]);
    $display("across phases with no idling, sender gaps, receiver stalls and both.");
    if (mismatches == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sacta_pkg.sv
rtl/core/sacta_ram.sv
rtl/core/sacta_tag_array.sv
rtl/core/sacta_data_array.sv
rtl/core/set_assoc_cache_tag_data_array_unit.sv
rtl/core/sacta_checker.sv
verif/sacta_result_checker.sv
verif/set_assoc_cache_tag_data_array_unit_tb.sv
